[rtl/sbsm_pkg.sv]
package sbsm_pkg;

	localparam int PRG_ADDR_BITS = 19;
	localparam int CHR_ADDR_BITS = 17;
	localparam int PRG_LOG2_MIN  = 14;
	localparam int CHR_LOG2_MIN  = 13;
	localparam int MEM_ADDR_W    = 19;
	localparam int CLK_W         = 48;
	localparam int CFG_DATA_W    = 5;
	localparam int IN_TDATA_W    = 72;
	localparam int OUT_TDATA_W   = 40;

	// shortest accepted spacing between CPU writes is this plus one
	localparam logic [CLK_W-1:0] WRITE_GAP_MIN = CLK_W'(6);

	typedef enum logic [1:0] {
		REQ_CPU_RD = 2'd0,
		REQ_CPU_WR = 2'd1,
		REQ_PPU_RD = 2'd2,
		REQ_PPU_WR = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		TGT_NONE    = 3'd0,
		TGT_PRG_ROM = 3'd1,
		TGT_PRG_RAM = 3'd2,
		TGT_CHR     = 3'd3,
		TGT_VRAM    = 3'd4
	} target_t;

	typedef enum logic [1:0] {
		CFG_PRG_SIZE_LOG2 = 2'd0,
		CFG_CHR_SIZE_LOG2 = 2'd1,
		CFG_CHR_IS_RAM    = 2'd2,
		CFG_UNUSED        = 2'd3
	} cfg_reg_t;

	// serial register destination, address bits 14:13
	typedef enum logic [1:0] {
		SREG_CONTROL = 2'd0,
		SREG_CHR_LO  = 2'd1,
		SREG_CHR_HI  = 2'd2,
		SREG_PRG     = 2'd3
	} sreg_t;

	// nametable mirroring, control register bits 1:0
	typedef enum logic [1:0] {
		MIRROR_LOWER = 2'd0,
		MIRROR_UPPER = 2'd1,
		MIRROR_VERT  = 2'd2,
		MIRROR_HORIZ = 2'd3
	} mirror_t;

	// all-ones mask of 2^l bytes, l saturated into [lo, hi]
	function automatic logic [MEM_ADDR_W-1:0] size_mask(
		input logic [CFG_DATA_W-1:0] l,
		input int                    lo,
		input int                    hi
	);
		logic [CFG_DATA_W-1:0] c;
		c = l;
		if (c < CFG_DATA_W'(lo))
			c = CFG_DATA_W'(lo);
		if (c > CFG_DATA_W'(hi))
			c = CFG_DATA_W'(hi);
		return ~({MEM_ADDR_W{1'b1}} << c);
	endfunction

endpackage

[rtl/serial_bank_switch_mapper_unit.sv]
// Channel  Dir  Handshake                     Payload
// s_axis   in   s_axis_tvalid/s_axis_tready   tuser: req_type; tdata: address, write_data, cpu_clock
// m_axis   out  m_axis_tvalid/m_axis_tready   tuser: target; tdata: mem_address, mem_write, ...
// cfg      in   cfg_valid/cfg_ready           cfg_index, cfg_data
//
// An input transaction passes the input register, then the result register.
// One access per cycle sustained while the result is not stalled; the mapper state updates as
// the item leaves the input register, so the following item already sees it.
// arst_n puts the mapper state and config registers at their reset values and clears
// both valid flags.
// A stalled result holds the input register; the input side stalls only once both are full.
module serial_bank_switch_mapper_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [sbsm_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // address, write_data, cpu_clock
	input  logic [1:0]                          s_axis_tuser,  // req_type
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [sbsm_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,  // mem_address, mem_write,
	                                                            // store_data, fixed_data, zero pad
	output logic [2:0]                          m_axis_tuser,  // target
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [1:0]                          cfg_index,
	input  logic [sbsm_pkg::CFG_DATA_W-1:0]     cfg_data
);

	// config, sizes kept as ready-made masks
	logic [sbsm_pkg::PRG_ADDR_BITS-1:0] prg_mask_q;
	logic [sbsm_pkg::CHR_ADDR_BITS-1:0] chr_mask_q;
	logic                               chr_is_ram_q;

	// mapper state
	logic [sbsm_pkg::CLK_W-1:0] last_write_clock_q;
	logic [2:0]                 shift_count_q;
	logic [4:0]                 shift_value_q;
	logic [1:0]                 mirror_mode_q;
	logic                       prg_mode_16k_q;
	logic                       prg_last_fixed_q;
	logic                       chr_mode_4k_q;
	logic [3:0]                 prg_bank_q;
	logic [4:0]                 chr_bank_lo_q;
	logic [4:0]                 chr_bank_hi_q;
	logic                       wram_off_q;

	// input register
	logic                       valid_s1;
	sbsm_pkg::req_t             req_s1;
	logic [15:0]                addr_s1;
	logic [7:0]                 data_s1;
	logic [sbsm_pkg::CLK_W-1:0] clk_s1;

	// result register
	logic                       out_valid_q;
	logic [2:0]                 target_q;
	logic [sbsm_pkg::OUT_TDATA_W-1:0] out_data_q;

	logic advance;

	// next-state and result
	sbsm_pkg::target_t              target_d;
	logic [sbsm_pkg::MEM_ADDR_W-1:0] maddr_d;
	logic                           mw_d;
	logic [7:0]                     fixed_d;
	logic                           wr_taken;   // CPU write passes spacing filter
	logic                           serial_en;
	logic [sbsm_pkg::CLK_W-1:0]     gap;
	logic [17:0]                    prg_raw;
	logic [16:0]                    chr_raw;
	logic                           nt_hi;
	logic [4:0]                     sh_val_next;
	logic [2:0]                     sh_cnt_next;

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign cfg_ready     = 1'b1;

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = target_q;
	assign m_axis_tdata  = out_data_q;

	always_comb begin
		// PRG ROM window, bank bits concatenated above the offset
		if (prg_mode_16k_q) begin
			if (!addr_s1[14])
				prg_raw = {(prg_last_fixed_q ? prg_bank_q : 4'h0), addr_s1[13:0]};
			else
				prg_raw = {(prg_last_fixed_q ? 4'hF : prg_bank_q), addr_s1[13:0]};
		end else begin
			prg_raw = {prg_bank_q[3:1], addr_s1[14:0]};
		end

		if (chr_mode_4k_q) begin
			chr_raw = {(addr_s1[12] ? chr_bank_hi_q : chr_bank_lo_q), addr_s1[11:0]};
		end else begin
			chr_raw = {chr_bank_lo_q[4:1], addr_s1[12:0]};
		end

		case (sbsm_pkg::mirror_t'(mirror_mode_q))
			sbsm_pkg::MIRROR_LOWER: nt_hi = 1'b0;
			sbsm_pkg::MIRROR_UPPER: nt_hi = 1'b1;
			sbsm_pkg::MIRROR_VERT:  nt_hi = addr_s1[10];
			default:                nt_hi = addr_s1[11];
		endcase

		gap      = clk_s1 - last_write_clock_q;
		wr_taken = 1'b0;
		serial_en = 1'b0;
		target_d = sbsm_pkg::TGT_NONE;
		maddr_d  = '0;
		mw_d     = 1'b0;
		fixed_d  = 8'h00;

		unique case (req_s1) inside
			sbsm_pkg::REQ_CPU_RD: begin
				if (addr_s1[15]) begin
					target_d = sbsm_pkg::TGT_PRG_ROM;
					maddr_d  = sbsm_pkg::MEM_ADDR_W'(prg_raw) & prg_mask_q;
				end else if (addr_s1[14:13] == 2'b11) begin
					if (wram_off_q) begin
						fixed_d = 8'hFF;
					end else begin
						target_d = sbsm_pkg::TGT_PRG_RAM;
						maddr_d  = sbsm_pkg::MEM_ADDR_W'(addr_s1[12:0]);
					end
				end
			end
			sbsm_pkg::REQ_CPU_WR: begin
				if ((addr_s1[15] || addr_s1[14:13] == 2'b11) && gap > sbsm_pkg::WRITE_GAP_MIN) begin
					wr_taken = 1'b1;
					if (!addr_s1[15]) begin
						if (!wram_off_q) begin
							target_d = sbsm_pkg::TGT_PRG_RAM;
							maddr_d  = sbsm_pkg::MEM_ADDR_W'(addr_s1[12:0]);
							mw_d     = 1'b1;
						end
					end else begin
						serial_en = 1'b1;
					end
				end
			end
			sbsm_pkg::REQ_PPU_RD, sbsm_pkg::REQ_PPU_WR: begin
				if (addr_s1[15:13] == 3'b000) begin
					target_d = sbsm_pkg::TGT_CHR;
					maddr_d  = sbsm_pkg::MEM_ADDR_W'(chr_raw & chr_mask_q);
					mw_d     = (req_s1 == sbsm_pkg::REQ_PPU_WR) && chr_is_ram_q;
				end else begin
					target_d = sbsm_pkg::TGT_VRAM;
					maddr_d  = sbsm_pkg::MEM_ADDR_W'({nt_hi, addr_s1[9:0]});
					mw_d     = (req_s1 == sbsm_pkg::REQ_PPU_WR);
				end
			end
			default: ;
		endcase

		sh_val_next = shift_value_q | 5'({4'h0, data_s1[0]} << shift_count_q);
		sh_cnt_next = shift_count_q + 3'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prg_mask_q   <= sbsm_pkg::size_mask(5'd18, sbsm_pkg::PRG_LOG2_MIN,
				sbsm_pkg::PRG_ADDR_BITS);
			chr_mask_q   <= sbsm_pkg::CHR_ADDR_BITS'(sbsm_pkg::size_mask(5'd13,
				sbsm_pkg::CHR_LOG2_MIN, sbsm_pkg::CHR_ADDR_BITS));
			chr_is_ram_q <= 1'b1;
		end else if (cfg_valid) begin
			case (cfg_index)
				sbsm_pkg::CFG_PRG_SIZE_LOG2:
					prg_mask_q <= sbsm_pkg::size_mask(cfg_data, sbsm_pkg::PRG_LOG2_MIN,
						sbsm_pkg::PRG_ADDR_BITS);
				sbsm_pkg::CFG_CHR_SIZE_LOG2:
					chr_mask_q <= sbsm_pkg::CHR_ADDR_BITS'(sbsm_pkg::size_mask(cfg_data,
						sbsm_pkg::CHR_LOG2_MIN, sbsm_pkg::CHR_ADDR_BITS));
				sbsm_pkg::CFG_CHR_IS_RAM:
					chr_is_ram_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_write_clock_q <= '0;
			shift_count_q      <= '0;
			shift_value_q      <= '0;
			mirror_mode_q      <= '0;
			prg_mode_16k_q     <= 1'b1;
			prg_last_fixed_q   <= 1'b1;
			chr_mode_4k_q      <= 1'b0;
			prg_bank_q         <= '0;
			chr_bank_lo_q      <= '0;
			chr_bank_hi_q      <= '0;
			wram_off_q         <= 1'b1;
		end else if (advance) begin
			if (wr_taken)
				last_write_clock_q <= clk_s1;
			if (serial_en) begin
				if (data_s1[7]) begin
					shift_count_q    <= '0;
					shift_value_q    <= '0;
					prg_mode_16k_q   <= 1'b1;
					prg_last_fixed_q <= 1'b1;
				end else if (sh_cnt_next == 3'd5) begin
					// fifth bit: commit to the register picked by address bits 14:13
					unique case (sbsm_pkg::sreg_t'(addr_s1[14:13]))
						sbsm_pkg::SREG_CONTROL: begin
							chr_mode_4k_q    <= sh_val_next[4];
							prg_mode_16k_q   <= sh_val_next[3];
							prg_last_fixed_q <= sh_val_next[2];
							mirror_mode_q    <= sh_val_next[1:0];
						end
						sbsm_pkg::SREG_CHR_LO: chr_bank_lo_q <= sh_val_next;
						sbsm_pkg::SREG_CHR_HI: chr_bank_hi_q <= sh_val_next;
						sbsm_pkg::SREG_PRG: begin
							prg_bank_q <= sh_val_next[3:0];
							wram_off_q <= sh_val_next[4];
						end
						default: ;
					endcase
					shift_count_q <= '0;
					shift_value_q <= '0;
				end else begin
					shift_count_q <= sh_cnt_next;
					shift_value_q <= sh_val_next;
				end
			end
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_axis_tready)
			valid_s1 <= s_axis_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			req_s1  <= sbsm_pkg::req_t'(s_axis_tuser);
			addr_s1 <= s_axis_tdata[15:0];
			data_s1 <= s_axis_tdata[23:16];
			clk_s1  <= s_axis_tdata[71:24];
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance)
			out_valid_q <= 1'b1;
		else if (m_axis_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			target_q   <= target_d;
			out_data_q <= {4'h0, fixed_d, (mw_d ? data_s1 : 8'h00), mw_d, maddr_d};
		end
	end

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps

module testbench;

	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int          PHASES      = 8;
	localparam int          PHASE_ITEMS = 135;
	localparam logic [47:0] SPACING_MIN = 48'd6;

	typedef struct {
		sbsm_pkg::req_t req;
		logic [15:0]    addr;
		logic [7:0]     data;
		logic [47:0]    cclk;
	} access_t;

	typedef struct {
		sbsm_pkg::target_t tgt;
		logic [18:0]       maddr;
		logic              mw;
		logic [7:0]        sdata;
		logic [7:0]        fdata;
	} map_result_t;

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             s_axis_tvalid = 1'b0;
	logic                             s_axis_tready;
	logic [sbsm_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;  // address, write_data, cpu_clock
	logic [1:0]                       s_axis_tuser = '0;  // req_type
	logic                             m_axis_tvalid;
	logic                             m_axis_tready = 1'b0;
	logic [sbsm_pkg::OUT_TDATA_W-1:0] m_axis_tdata;  // mem_address, mem_write, store_data,
	                                                 // fixed_data
	logic [2:0]                       m_axis_tuser;  // target
	logic                             cfg_valid = 1'b0;
	logic                             cfg_ready;
	logic [1:0]                       cfg_index = '0;
	logic [sbsm_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

	serial_bank_switch_mapper_unit u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// mapper state as the predictor sees it
	logic [47:0] wr_clk_last;
	logic [2:0]  ser_cnt;
	logic [4:0]  ser_val;
	logic [1:0]  mirror_sel;
	logic        prg_16k, prg_fix_last, chr_4k, wram_dis;
	logic [3:0]  prg_sel;
	logic [4:0]  chr_sel_lo, chr_sel_hi;
	logic [4:0]  prg_log2, chr_log2;
	logic        chr_ram;

	access_t     pending_accesses[$];
	map_result_t expected_results[$];
	access_t     cur_access;
	logic        no_idle = 1'b0;
	int unsigned mismatches = 0;
	int unsigned cycle_count = 0;
	logic [47:0] clk_now;

	function automatic int wrap_mask(input logic [4:0] l, input int lo, input int hi);
		int c;
		c = int'(l);
		if (c < lo)
			c = lo;
		if (c > hi)
			c = hi;
		return (1 << c) - 1;
	endfunction

	function automatic logic [18:0] prg_offset(input logic [15:0] a);
		int off, base;
		off = int'(a) - 'h8000;
		if (prg_16k) begin
			if (off < 'h4000) begin
				base = prg_fix_last ? prg_sel * 'h4000 : 0;
			end else begin
				off  = off - 'h4000;
				base = prg_fix_last ? 'hF * 'h4000 : prg_sel * 'h4000;
			end
		end else begin
			base = (prg_sel >> 1) * 'h8000;
		end
		return 19'((base + off) &
			wrap_mask(prg_log2, sbsm_pkg::PRG_LOG2_MIN, sbsm_pkg::PRG_ADDR_BITS));
	endfunction

	function automatic logic [18:0] chr_offset(input logic [15:0] a);
		int ia, r;
		ia = int'(a);
		if (chr_4k)
			r = (ia < 'h1000) ? chr_sel_lo * 'h1000 + ia : chr_sel_hi * 'h1000 + (ia - 'h1000);
		else
			r = (chr_sel_lo >> 1) * 'h2000 + ia;
		return 19'(r & wrap_mask(chr_log2, sbsm_pkg::CHR_LOG2_MIN, sbsm_pkg::CHR_ADDR_BITS));
	endfunction

	function automatic logic [18:0] vram_offset(input logic [15:0] a);
		int n, hi;
		n = int'(a) & 'hFFF;
		case (sbsm_pkg::mirror_t'(mirror_sel))
		sbsm_pkg::MIRROR_LOWER: hi = 0;
		sbsm_pkg::MIRROR_UPPER: hi = 1;
		sbsm_pkg::MIRROR_VERT:  hi = (n >> 10) & 1;
		default: hi = (n >> 11) & 1;
		endcase
		return 19'((n & 'h3FF) + hi * 'h400);
	endfunction

	task automatic shift_in(input logic [15:0] a, input logic [7:0] d);
		if (d[7]) begin
			ser_cnt      = '0;
			ser_val      = '0;
			prg_16k      = 1'b1;
			prg_fix_last = 1'b1;
		end else begin
			ser_val = ser_val | (5'(d[0]) << ser_cnt);
			ser_cnt = ser_cnt + 3'd1;
			if (ser_cnt == 3'd5) begin
				case (sbsm_pkg::sreg_t'(a[14:13]))
				sbsm_pkg::SREG_CONTROL: begin
					chr_4k       = ser_val[4];
					prg_16k      = ser_val[3];
					prg_fix_last = ser_val[2];
					mirror_sel   = ser_val[1:0];
				end
				sbsm_pkg::SREG_CHR_LO: chr_sel_lo = ser_val;
				sbsm_pkg::SREG_CHR_HI: chr_sel_hi = ser_val;
				default: begin
					prg_sel  = ser_val[3:0];
					wram_dis = ser_val[4];
				end
				endcase
				ser_cnt = '0;
				ser_val = '0;
			end
		end
	endtask

	task automatic translate_access(input access_t x);
		map_result_t r;
		r.tgt   = sbsm_pkg::TGT_NONE;
		r.maddr = '0;
		r.mw    = 1'b0;
		r.fdata = '0;
		case (x.req)
		sbsm_pkg::REQ_CPU_RD: begin
			if (x.addr >= 16'h8000) begin
				r.tgt   = sbsm_pkg::TGT_PRG_ROM;
				r.maddr = prg_offset(x.addr);
			end else if (x.addr >= 16'h6000) begin
				if (wram_dis) begin
					r.fdata = 8'hFF;
				end else begin
					r.tgt   = sbsm_pkg::TGT_PRG_RAM;
					r.maddr = 19'(x.addr - 16'h6000);
				end
			end
		end
		sbsm_pkg::REQ_CPU_WR: begin
			// modulo-2^48 spacing filter against the last accepted write
			if (x.addr >= 16'h6000 && 48'(x.cclk - wr_clk_last) > SPACING_MIN) begin
				wr_clk_last = x.cclk;
				if (x.addr < 16'h8000) begin
					if (!wram_dis) begin
						r.tgt   = sbsm_pkg::TGT_PRG_RAM;
						r.maddr = 19'(x.addr - 16'h6000);
						r.mw    = 1'b1;
					end
				end else begin
					shift_in(x.addr, x.data);
				end
			end
		end
		default: begin
			if (x.addr < 16'h2000) begin
				r.tgt   = sbsm_pkg::TGT_CHR;
				r.maddr = chr_offset(x.addr);
				r.mw    = (x.req == sbsm_pkg::REQ_PPU_WR) && chr_ram;
			end else begin
				r.tgt   = sbsm_pkg::TGT_VRAM;
				r.maddr = vram_offset(x.addr);
				r.mw    = (x.req == sbsm_pkg::REQ_PPU_WR);
			end
		end
		endcase
		r.sdata = r.mw ? x.data : 8'h00;
		expected_results.push_back(r);
	endtask

	task automatic check_field(input string name, input longint unsigned want,
	                           input longint unsigned got);
		if (want != got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatches++;
		end
	endtask

	// driver
	always @(posedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				translate_access(cur_access);
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pending_accesses.size() != 0 && (no_idle || $urandom_range(99) >= 10)) begin
					cur_access = pending_accesses.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= {cur_access.cclk, cur_access.data, cur_access.addr};
					s_axis_tuser  <= cur_access.req;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		map_result_t want;
		m_axis_tready <= no_idle || ($urandom_range(99) >= 10);
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_results.size() == 0) begin
				$error("result transaction with nothing pending: target %0d", m_axis_tuser);
				mismatches++;
			end else begin
				want = expected_results.pop_front();
				check_field("target", want.tgt, m_axis_tuser);
				check_field("mem_address", want.maddr, m_axis_tdata[18:0]);
				check_field("mem_write", want.mw, m_axis_tdata[19]);
				check_field("store_data", want.sdata, m_axis_tdata[27:20]);
				check_field("fixed_data", want.fdata, m_axis_tdata[35:28]);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("serial_bank_switch_mapper_unit verification failed");
			$finish;
		end
	end

	task automatic push_access(input sbsm_pkg::req_t rq, input logic [15:0] a,
	                           input logic [7:0] d, input logic [47:0] c);
		access_t x;
		x.req  = rq;
		x.addr = a;
		x.data = d;
		x.cclk = c;
		pending_accesses.push_back(x);
	endtask

	task automatic tick_clock(input logic spaced);
		if ($urandom_range(99) < 2)
			clk_now = {16'($urandom), $urandom};
		else if (spaced)
			clk_now = clk_now + 48'($urandom_range(60, 7));
		else
			clk_now = clk_now + 48'($urandom_range(6, 0));
	endtask

	// five well-spaced serial writes; only the last address picks the register
	task automatic load_sreg(input sbsm_pkg::sreg_t dst, input logic [4:0] v);
		logic [15:0] a;
		for (int i = 0; i < 5; i++) begin
			clk_now = clk_now + 48'($urandom_range(40, 7));
			a = (i == 4) ? {1'b1, dst, 13'($urandom)} : (16'h8000 | 16'($urandom_range(32767)));
			push_access(sbsm_pkg::REQ_CPU_WR, a, {1'b0, 6'($urandom), v[i]}, clk_now);
		end
	endtask

	task automatic random_access();
		sbsm_pkg::req_t rq;
		logic [15:0]    a;
		int             pick;
		rq   = sbsm_pkg::req_t'($urandom_range(3));
		pick = $urandom_range(99);
		case (rq)
		sbsm_pkg::REQ_CPU_RD:
			a = pick < 60 ? (16'h8000 | 16'($urandom_range(32767)))
			  : pick < 85 ? (16'h6000 + 16'($urandom_range(8191))) : 16'($urandom);
		sbsm_pkg::REQ_CPU_WR:
			a = pick < 50 ? (16'h6000 + 16'($urandom_range(8191))) : 16'($urandom);
		default:
			a = pick < 60 ? 16'($urandom_range(8191)) : 16'($urandom);
		endcase
		tick_clock($urandom_range(99) < 80);
		push_access(rq, a, 8'($urandom), clk_now);
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (pending_accesses.size() != 0 || s_axis_tvalid || expected_results.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_cfg(input sbsm_pkg::cfg_reg_t idx, input logic [4:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		do @(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
		sbsm_pkg::CFG_PRG_SIZE_LOG2: prg_log2 = v;
		sbsm_pkg::CFG_CHR_SIZE_LOG2: chr_log2 = v;
		sbsm_pkg::CFG_CHR_IS_RAM:    chr_ram  = v[0];
		default: ;
		endcase
	endtask

	initial begin
		logic [4:0] prg_set[PHASES];
		logic [4:0] chr_set[PHASES];
		logic       ram_set[PHASES];
		int         count;
		int         pick;

		prg_set = '{5'd18, 5'd14, 5'd19, 5'd0, 5'd31, 5'd16, 5'd17, 5'd15};
		chr_set = '{5'd13, 5'd13, 5'd17, 5'd0, 5'd31, 5'd15, 5'd14, 5'd16};
		ram_set = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};

		wr_clk_last  = '0;
		ser_cnt      = '0;
		ser_val      = '0;
		mirror_sel   = 2'd0;
		prg_16k      = 1'b1;
		prg_fix_last = 1'b1;
		chr_4k       = 1'b0;
		prg_sel      = '0;
		chr_sel_lo   = '0;
		chr_sel_hi   = '0;
		wram_dis     = 1'b1;
		prg_log2     = 5'd18;
		chr_log2     = 5'd13;
		chr_ram      = 1'b1;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// low CPU space, disabled work RAM, spacing filter
		push_access(sbsm_pkg::REQ_CPU_RD, 16'h0000, 8'h00, 48'd10);
		push_access(sbsm_pkg::REQ_CPU_RD, 16'h5FFF, 8'hFF, 48'd10);
		push_access(sbsm_pkg::REQ_CPU_WR, 16'h0000, 8'h55, 48'd11);
		push_access(sbsm_pkg::REQ_CPU_RD, 16'h6000, 8'h00, 48'd12);
		push_access(sbsm_pkg::REQ_CPU_WR, 16'h7FFF, 8'hAA, 48'd20);
		push_access(sbsm_pkg::REQ_CPU_WR, 16'h6000, 8'h01, 48'd26);
		// PRG window edges
		push_access(sbsm_pkg::REQ_CPU_RD, 16'h8000, 8'h00, 48'd27);
		push_access(sbsm_pkg::REQ_CPU_RD, 16'hBFFF, 8'h00, 48'd27);
		push_access(sbsm_pkg::REQ_CPU_RD, 16'hC000, 8'h00, 48'd28);
		push_access(sbsm_pkg::REQ_CPU_RD, 16'hFFFF, 8'h00, 48'd28);
		// PPU: CHR and nametables
		push_access(sbsm_pkg::REQ_PPU_RD, 16'h0000, 8'h00, 48'd29);
		push_access(sbsm_pkg::REQ_PPU_RD, 16'h1FFF, 8'h00, 48'd29);
		push_access(sbsm_pkg::REQ_PPU_WR, 16'h1000, 8'h3C, 48'd30);
		push_access(sbsm_pkg::REQ_PPU_RD, 16'h2000, 8'h00, 48'd30);
		push_access(sbsm_pkg::REQ_PPU_WR, 16'hFFFF, 8'hC3, 48'd31);
		push_access(sbsm_pkg::REQ_PPU_RD, 16'h3FFF, 8'h00, 48'd31);
		// serial reset, then a write too close behind it
		push_access(sbsm_pkg::REQ_CPU_WR, 16'h8000, 8'h80, 48'd40);
		push_access(sbsm_pkg::REQ_CPU_WR, 16'hFFFF, 8'h7F, 48'd46);
		// spacing across clock wraparound
		push_access(sbsm_pkg::REQ_CPU_WR, 16'hE000, 8'h01, 48'hFFFF_FFFF_FFFF);
		push_access(sbsm_pkg::REQ_CPU_WR, 16'hE000, 8'h01, 48'd5);
		push_access(sbsm_pkg::REQ_CPU_WR, 16'hE000, 8'h00, 48'd7);
		clk_now = 48'd1000;

		for (int p = 0; p < PHASES; p++) begin
			if (p != 0) begin
				wait_drained();
				write_cfg(sbsm_pkg::CFG_PRG_SIZE_LOG2, prg_set[p]);
				write_cfg(sbsm_pkg::CFG_CHR_SIZE_LOG2, chr_set[p]);
				write_cfg(sbsm_pkg::CFG_CHR_IS_RAM, 5'(ram_set[p]));
				if (p == 5)
					write_cfg(sbsm_pkg::CFG_UNUSED, 5'($urandom));
			end
			no_idle = (p == 6);
			count = 0;
			while (count < PHASE_ITEMS) begin
				pick = $urandom_range(99);
				if (pick < 25) begin
					if ($urandom_range(99) < 20) begin
						clk_now = clk_now + 48'($urandom_range(40, 7));
						push_access(sbsm_pkg::REQ_CPU_WR,
						            16'h8000 | 16'($urandom_range(32767)),
						            8'h80 | 8'($urandom), clk_now);
						count++;
					end
					load_sreg(sbsm_pkg::sreg_t'($urandom_range(3)), 5'($urandom));
					count += 5;
				end else if (pick < 35) begin
					tick_clock(1'($urandom_range(1)));
					push_access(sbsm_pkg::REQ_CPU_WR, 16'($urandom), 8'($urandom), clk_now);
					count++;
				end else begin
					random_access();
					count++;
				end
			end
		end

		wait_drained();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("serial_bank_switch_mapper_unit verification clean");
		else
			$display("serial_bank_switch_mapper_unit verification failed");
		$finish;
	end

endmodule
